### rtl/core/gcb_pkg.sv
package gcb_pkg;

  // Default sizes of the resonator bank.
  localparam int DEF_MAX_NOTES  = 64;
  localparam int DEF_MAX_FRAMES = 8;

  // Port and field types.
  typedef logic signed [15:0] sample_t;
  typedef logic signed [17:0] coef_t;
  typedef logic        [23:0] sens_t;
  typedef logic        [5:0]  note_t;
  typedef logic        [16:0] chroma_t;
  typedef logic        [31:0] power_t;
  typedef logic        [3:0]  cfg_addr_t;
  typedef logic        [31:0] cfg_data_t;
  typedef logic signed [47:0] res_t;

  // Configuration register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_FRAME_LENGTH  = 2'd0,
    REG_FRAME_SPACING = 2'd1,
    REG_ACTIVE_NOTES  = 2'd2,
    REG_PEAK_FLOOR    = 2'd3
  } reg_idx_t;

  localparam logic [15:0] FRAME_LENGTH_RST  = 16'd4096;
  localparam logic [15:0] FRAME_SPACING_RST = 16'd1024;
  localparam logic [6:0]  ACTIVE_NOTES_RST  = 7'd12;
  localparam logic [31:0] PEAK_FLOOR_RST    = 32'd1678;

  // Arithmetic limits.
  localparam logic [5:0]  DIV_STEPS  = 6'd32;
  localparam logic [31:0] AMP_LIM    = 32'h8000_0000;
  localparam logic [16:0] CHROMA_MAX = 17'h1_0000;
  localparam logic [31:0] UNIT_PEAK  = 32'h0100_0000;
  localparam logic [31:0] POWER_MAX  = 32'hFFFF_FFFF;
  localparam res_t        RES_HI     = 48'sh7FFF_FFFF_FFFF;
  localparam res_t        RES_LO     = -48'sh7FFF_FFFF_FFFF - 48'sd1;

endpackage

### rtl/core/goertzel_chroma_bank.sv
// A sample transaction scans the frame slots and runs each active note of every live frame
// through the resonator update; the frame that completes with output adds two divisions
// per note, a tracker update and one division per result, waiting while the output is
// stalled. The shared 33x33 multiplier and the bit-serial divider carry this work.
// Synchronous active-low reset clears control state, frame slots and the peak tracker; the
// resonator memory is not swept, a newly started frame reads its state as zero.
module goertzel_chroma_bank #(
  parameter int MAX_NOTES  = gcb_pkg::DEF_MAX_NOTES,
  parameter int MAX_FRAMES = gcb_pkg::DEF_MAX_FRAMES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  gcb_pkg::sample_t   in_sample,
  input  gcb_pkg::note_t     in_coef_note,
  input  gcb_pkg::coef_t     in_cos_coef,
  input  gcb_pkg::coef_t     in_sin_coef,
  input  gcb_pkg::sens_t     in_sensitivity,
  input  logic               in_suppress_output,
  output logic               out_valid,
  input  logic               out_stall,
  output gcb_pkg::note_t     out_note_number,
  output gcb_pkg::chroma_t   out_chroma,
  output gcb_pkg::power_t    out_frame_peak,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  gcb_pkg::cfg_addr_t cfg_paddr,
  input  gcb_pkg::cfg_data_t cfg_pwdata,
  output gcb_pkg::cfg_data_t cfg_prdata,
  output logic               cfg_pready
);
  import gcb_pkg::*;

  localparam int NOTE_W  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int FR_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NCNT_W  = $clog2(MAX_NOTES + 1);
  localparam int RADDR_W = FR_W + NOTE_W;
  localparam int RDEPTH  = 1 << RADDR_W;

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_FSCAN = 24'h000002,
    S_RD    = 24'h000004,
    S_M1    = 24'h000008,
    S_M2    = 24'h000010,
    S_UPD   = 24'h000020,
    S_E1    = 24'h000040,
    S_E2    = 24'h000080,
    S_E3    = 24'h000100,
    S_E4    = 24'h000200,
    S_E5    = 24'h000400,
    S_DA    = 24'h000800,
    S_DB    = 24'h001000,
    S_Q1    = 24'h002000,
    S_Q2    = 24'h004000,
    S_Q3    = 24'h008000,
    S_Q4    = 24'h010000,
    S_Q5    = 24'h020000,
    S_FDONE = 24'h040000,
    S_T1    = 24'h080000,
    S_T2    = 24'h100000,
    S_ORD   = 24'h200000,
    S_ODIV  = 24'h400000,
    S_OWT   = 24'h800000
  } state_t;

  // Configuration registers.
  logic [15:0] frame_length_r, frame_spacing_r;
  logic [6:0]  active_notes_r;
  logic [31:0] peak_floor_r;
  logic        cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r  <= FRAME_LENGTH_RST;
      frame_spacing_r <= FRAME_SPACING_RST;
      active_notes_r  <= ACTIVE_NOTES_RST;
      peak_floor_r    <= PEAK_FLOOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_FRAME_LENGTH:  frame_length_r  <= cfg_pwdata[15:0];
        REG_FRAME_SPACING: frame_spacing_r <= cfg_pwdata[15:0];
        REG_ACTIVE_NOTES:  active_notes_r  <= cfg_pwdata[6:0];
        REG_PEAK_FLOOR:    peak_floor_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_FRAME_LENGTH:  cfg_prdata = {16'd0, frame_length_r};
      REG_FRAME_SPACING: cfg_prdata = {16'd0, frame_spacing_r};
      REG_ACTIVE_NOTES:  cfg_prdata = {25'd0, active_notes_r};
      REG_PEAK_FLOOR:    cfg_prdata = peak_floor_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // Control state.
  state_t              state_r;
  logic [MAX_FRAMES-1:0] live_r;
  logic [15:0]         pos_r [MAX_FRAMES];
  logic [NCNT_W-1:0]   nval_r [MAX_FRAMES];
  logic [15:0]         spacing_r;
  logic [31:0]         tracked_r;
  logic                emitted_r;
  logic                out_valid_r;
  logic [5:0]          div_cnt_r;
  logic [FR_W-1:0]     fi_r;
  logic [NOTE_W-1:0]   k_r;

  // Datapath registers.
  sample_t             x_r;
  logic                sup_r, emit_r, fresh_r;
  res_t                s1_r, s2_r, sn_r;
  coef_t               cos_r, sin_r;
  sens_t               sens_r;
  logic signed [65:0]  prod_r, acc_r;
  logic signed [49:0]  yr_r, yi_r;
  logic [31:0]         ar_r, ai_r, p_r, peak_acc_r, pq_r;
  logic [32:0]         t_r, peak_r;
  note_t               out_note_r;
  chroma_t             out_chroma_r;
  power_t              out_peak_r;
  logic                out_last_r;

  // Divider registers.
  logic [32:0] div_rem_r, div_den_r;
  logic [31:0] div_q_r;
  logic        div_ovf_r;

  // Memories.
  res_t  first_mem  [RDEPTH];
  res_t  second_mem [RDEPTH];
  coef_t cos_mem    [MAX_NOTES];
  coef_t sin_mem    [MAX_NOTES];
  sens_t sens_mem   [MAX_NOTES];
  power_t pow_mem   [MAX_NOTES];

  // Derived control values.
  logic [15:0]       len;
  logic [NCNT_W-1:0] nn;
  logic              k_last, fi_last, frame_done;
  logic [16:0]       spacing_inc;
  logic              spacing_wrap;
  logic              slot_found;
  logic [FR_W-1:0]   slot_idx;
  logic [RADDR_W-1:0] raddr;
  logic              load_acc, sample_acc, out_free, div_done;

  assign len = (frame_length_r == 16'd0) ? 16'd1 : frame_length_r;

  always_comb begin
    if (active_notes_r == 7'd0) begin
      nn = NCNT_W'(1);
    end else if ({1'b0, active_notes_r} > 8'(MAX_NOTES)) begin
      nn = NCNT_W'(MAX_NOTES);
    end else begin
      nn = NCNT_W'(active_notes_r);
    end
  end

  assign k_last       = (NCNT_W'(k_r) + NCNT_W'(1)) == nn;
  assign fi_last      = fi_r == FR_W'(MAX_FRAMES - 1);
  assign frame_done   = ({1'b0, pos_r[fi_r]} + 17'd1) >= {1'b0, len};
  assign spacing_inc  = {1'b0, spacing_r} + 17'd1;
  assign spacing_wrap = spacing_inc >= {1'b0, frame_spacing_r};
  assign raddr        = {fi_r, k_r};
  assign load_acc     = (state_r == S_IDLE) && in_valid && in_req_type;
  assign sample_acc   = (state_r == S_IDLE) && in_valid && !in_req_type;
  assign out_free     = !out_valid_r || !out_stall;
  assign div_done     = div_cnt_r == 6'd0;

  // Lowest free frame slot.
  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        slot_found = 1'b1;
        slot_idx   = FR_W'(i);
      end
    end
  end

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_note_number = out_note_r;
  assign out_chroma      = out_chroma_r;
  assign out_frame_peak  = out_peak_r;
  assign out_last        = out_last_r;

  // A frame that has just started has cleared resonators, and so has every note of a live
  // frame that no sample has updated yet since the frame started.
  logic note_fresh;
  res_t s1_v, s2_v;
  assign note_fresh = fresh_r || (NCNT_W'(k_r) >= nval_r[fi_r]);
  assign s1_v = note_fresh ? '0 : s1_r;
  assign s2_v = note_fresh ? '0 : s2_r;

  // Shared multiplier operand selection.
  logic signed [32:0] mul_a, mul_b, s1_hi, s1_lo;
  assign s1_hi = 33'($signed(s1_v[47:16]));
  assign s1_lo = $signed({17'd0, s1_v[15:0]});

  always_comb begin
    case (state_r)
      S_M1, S_E1: begin
        mul_a = s1_hi;
        mul_b = 33'(cos_r);
      end
      S_M2, S_E2: begin
        mul_a = s1_lo;
        mul_b = 33'(cos_r);
      end
      S_E3: begin
        mul_a = s1_hi;
        mul_b = 33'(sin_r);
      end
      S_E4: begin
        mul_a = s1_lo;
        mul_b = 33'(sin_r);
      end
      S_Q1: begin
        mul_a = $signed({1'b0, ar_r});
        mul_b = $signed({1'b0, ar_r});
      end
      S_Q2: begin
        mul_a = $signed({1'b0, ai_r});
        mul_b = $signed({1'b0, ai_r});
      end
      S_Q4: begin
        mul_a = $signed({1'b0, p_r});
        mul_b = $signed({9'd0, sens_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [65:0] mul_sum;
  assign mul_sum = acc_r + prod_r;

  // Resonator update with 48-bit saturation.
  logic signed [50:0] upd_t;
  logic signed [51:0] upd_sum;
  res_t               sn;
  assign upd_t   = $signed(mul_sum[65:15]);
  assign upd_sum = 52'(x_r) + 52'(upd_t) - 52'(s2_v);

  always_comb begin
    if (upd_sum[51] && !(&upd_sum[50:47])) begin
      sn = RES_LO;
    end else if (!upd_sum[51] && (|upd_sum[50:47])) begin
      sn = RES_HI;
    end else begin
      sn = upd_sum[47:0];
    end
  end

  // Magnitudes of the resonator outputs.
  logic [49:0] yr_mag, yi_mag;
  assign yr_mag = yr_r[49] ? 50'(-yr_r) : 50'(yr_r);
  assign yi_mag = yi_r[49] ? 50'(-yi_r) : 50'(yi_r);

  // Divider start selection.
  logic        div_start;
  logic [63:0] div_num;
  logic [32:0] div_den;

  assign div_start = (state_r == S_E5) || ((state_r == S_DA) && div_done) ||
                     (state_r == S_ODIV);

  always_comb begin
    case (state_r)
      S_E5: begin
        div_num = 64'(yr_mag) << 10;
        div_den = {17'd0, len};
      end
      S_DA: begin
        div_num = 64'(yi_mag) << 10;
        div_den = {17'd0, len};
      end
      S_ODIV: begin
        div_num = {16'd0, pq_r, 16'd0};
        div_den = peak_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  logic [33:0] div_trial;
  logic        div_ge;
  logic [31:0] amp_q;
  logic [16:0] chroma_q;
  assign div_trial = {div_rem_r, div_q_r[31]};
  assign div_ge    = div_trial >= {1'b0, div_den_r};
  assign amp_q     = (div_ovf_r || div_q_r > AMP_LIM) ? AMP_LIM : div_q_r;
  assign chroma_q  = (div_ovf_r || div_q_r > 32'(CHROMA_MAX)) ? CHROMA_MAX : div_q_r[16:0];

  // Restoring divider, one quotient bit per cycle. An overflow flag covers quotients
  // that do not fit in 32 bits.
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem_r <= {1'b0, div_num[63:32]};
      div_q_r   <= div_num[31:0];
      div_den_r <= div_den;
      div_ovf_r <= {1'b0, div_num[63:32]} >= div_den;
    end else if (!div_done) begin
      div_rem_r <= div_ge ? 33'(div_trial - {1'b0, div_den_r}) : div_trial[32:0];
      div_q_r   <= {div_q_r[30:0], div_ge};
    end
  end

  // Power and tracker arithmetic.
  logic [31:0] power_sq, power_w;
  logic [41:0] tr_mul;
  logic [32:0] t1, t_floor;
  logic [38:0] t_mul;
  logic [32:0] t_dec;
  logic        zero_peak;

  assign power_sq  = (|mul_sum[65:56]) ? POWER_MAX : mul_sum[55:24];
  assign power_w   = (|prod_r[65:48]) ? POWER_MAX : prod_r[47:16];
  assign tr_mul    = {tracked_r, 10'd0} - {10'd0, tracked_r};
  assign t1        = {11'd0, peak_acc_r[31:10]} + {1'b0, tr_mul[41:10]};
  assign t_floor   = (t1 < {1'b0, peak_floor_r}) ? {1'b0, peak_floor_r} : t1;
  assign t_mul     = {t_r, 6'd0} - {6'd0, t_r};
  assign t_dec     = {7'd0, peak_acc_r[31:6]} + t_mul[38:6];
  assign zero_peak = peak_r == 33'd0;

  // Memories.
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      first_mem[raddr]  <= sn;
      second_mem[raddr] <= s1_v;
    end
    if (state_r == S_RD) begin
      s1_r <= first_mem[raddr];
      s2_r <= second_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc && ({2'd0, in_coef_note} < 8'(MAX_NOTES))) begin
      cos_mem[NOTE_W'(in_coef_note)]  <= in_cos_coef;
      sin_mem[NOTE_W'(in_coef_note)]  <= in_sin_coef;
      sens_mem[NOTE_W'(in_coef_note)] <= in_sensitivity;
    end
    if (state_r == S_RD) begin
      cos_r  <= cos_mem[k_r];
      sin_r  <= sin_mem[k_r];
      sens_r <= sens_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_Q5) begin
      pow_mem[k_r] <= power_w;
    end
    if (state_r == S_ORD) begin
      pq_r <= pow_mem[k_r];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (sample_acc) begin
          x_r   <= in_sample;
          sup_r <= in_suppress_output;
        end
      end
      S_FSCAN: begin
        fresh_r    <= pos_r[fi_r] == 16'd0;
        emit_r     <= frame_done && !sup_r && !emitted_r;
        peak_acc_r <= '0;
      end
      S_M2, S_E2, S_E4: acc_r <= prod_r <<< 16;
      S_Q2:  acc_r <= prod_r;
      S_UPD: sn_r  <= sn;
      S_E3:  yr_r  <= 50'(sn_r) - $signed(mul_sum[65:16]);
      S_E5:  yi_r  <= $signed(mul_sum[65:16]);
      S_DA:  if (div_done) ar_r <= amp_q;
      S_DB:  if (div_done) ai_r <= amp_q;
      S_Q3:  p_r <= power_sq;
      S_Q5:  if (power_w > peak_acc_r) peak_acc_r <= power_w;
      S_T1:  t_r <= t_floor;
      S_T2:  peak_r <= (t_r > {1'b0, peak_acc_r}) ? t_r : {1'b0, peak_acc_r};
      S_OWT: begin
        if (div_done && out_free) begin
          out_note_r   <= 6'(k_r);
          out_chroma_r <= zero_peak ? '0 : chroma_q;
          out_peak_r   <= zero_peak ? UNIT_PEAK : peak_r[31:0];
          out_last_r   <= k_last;
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      spacing_r   <= '0;
      tracked_r   <= '0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      fi_r        <= '0;
      k_r         <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        pos_r[i]  <= '0;
        nval_r[i] <= '0;
      end
    end else begin
      if ((state_r == S_OWT) && div_done && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (div_start) begin
        div_cnt_r <= DIV_STEPS;
      end else if (!div_done) begin
        div_cnt_r <= div_cnt_r - 6'd1;
      end

      case (state_r)
        S_IDLE: begin
          if (sample_acc) begin
            if (spacing_r == 16'd0 && slot_found) begin
              live_r[slot_idx] <= 1'b1;
              pos_r[slot_idx]  <= '0;
            end
            spacing_r <= spacing_wrap ? 16'd0 : spacing_inc[15:0];
            emitted_r <= 1'b0;
            fi_r      <= '0;
            state_r   <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (live_r[fi_r]) begin
            k_r     <= '0;
            state_r <= S_RD;
          end else if (fi_last) begin
            state_r <= S_IDLE;
          end else begin
            fi_r <= fi_r + FR_W'(1);
          end
        end
        S_RD: state_r <= S_M1;
        S_M1: state_r <= S_M2;
        S_M2: state_r <= S_UPD;
        S_UPD: begin
          if (emit_r) begin
            state_r <= S_E1;
          end else if (k_last) begin
            state_r <= S_FDONE;
          end else begin
            k_r     <= k_r + NOTE_W'(1);
            state_r <= S_RD;
          end
        end
        S_E1: state_r <= S_E2;
        S_E2: state_r <= S_E3;
        S_E3: state_r <= S_E4;
        S_E4: state_r <= S_E5;
        S_E5: state_r <= S_DA;
        S_DA: if (div_done) state_r <= S_DB;
        S_DB: if (div_done) state_r <= S_Q1;
        S_Q1: state_r <= S_Q2;
        S_Q2: state_r <= S_Q3;
        S_Q3: state_r <= S_Q4;
        S_Q4: state_r <= S_Q5;
        S_Q5: begin
          if (k_last) begin
            state_r <= S_FDONE;
          end else begin
            k_r     <= k_r + NOTE_W'(1);
            state_r <= S_RD;
          end
        end
        S_FDONE: begin
          if (frame_done) begin
            live_r[fi_r] <= 1'b0;
            pos_r[fi_r]  <= '0;
          end else begin
            pos_r[fi_r] <= pos_r[fi_r] + 16'd1;
            if (fresh_r || (nn > nval_r[fi_r])) begin
              nval_r[fi_r] <= nn;
            end
          end
          if (frame_done && emit_r) begin
            emitted_r <= 1'b1;
            state_r   <= S_T1;
          end else if (fi_last) begin
            state_r <= S_IDLE;
          end else begin
            fi_r    <= fi_r + FR_W'(1);
            state_r <= S_FSCAN;
          end
        end
        S_T1: state_r <= S_T2;
        S_T2: begin
          // The slow tracker only follows the frame peak when it does not exceed it.
          tracked_r <= (t_r > {1'b0, peak_acc_r}) ? t_r[31:0] : t_dec[31:0];
          k_r       <= '0;
          state_r   <= S_ORD;
        end
        S_ORD:  state_r <= S_ODIV;
        S_ODIV: state_r <= S_OWT;
        S_OWT: begin
          if (div_done && out_free) begin
            if (!k_last) begin
              k_r     <= k_r + NOTE_W'(1);
              state_r <= S_ORD;
            end else if (fi_last) begin
              state_r <= S_IDLE;
            end else begin
              fi_r    <= fi_r + FR_W'(1);
              state_r <= S_FSCAN;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
